// File: sv/b2da_pkg.sv
// shared types and constants of the binary to decimal ascii converter
package b2da_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned BITS_W  = 5;
  localparam int unsigned DATA_W  = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [BITS_W-1:0] LAST_BIT   = 5'd31;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take a new value, clear the digit register
    logic shift;  // one shift-add-3 step
    logic drop;   // move to the next digit
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic bit_last;  // this shift consumes the final binary bit
    logic top_zero;  // leading digit is zero
    logic one_left;  // exactly one digit still to go
    logic ovf;       // value had more digits than the register holds
  } sts_t;

endpackage

// File: sv/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
//
//  channel   dir   tdata bits                tuser  tlast
//  s_axis    in    [31:0] value              -      -
//  m_axis    out   [5:0] digit_char, pad 0   -      last digit of the value
//
// one value is taken at a time; after acceptance it is converted by shift-add-3
// steps in the digit register, one binary bit per cycle, then leading zeros
// are skipped and the digits are emitted, most significant first
// a stall on m_axis holds the current digit; s_axis tready stays low until the
// last digit is taken; reset returns the controller to idle
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [VALUE_W-1:0]  s_axis_tdata_i,  // [31:0] value
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [DATA_W-1:0]   m_axis_tdata_o,  // [5:0] digit_char, [7:6] zero
  output logic                m_axis_tlast_o
);

  localparam int unsigned ND = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 20) ? 20 : MAX_DIGITS);

  cmd_t              cmd;
  sts_t              sts;
  logic [CHAR_W-1:0] digit_char;

  // controller
  b2da_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath
  b2da_dp #(
    .ND (ND)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata_i),
    .sts_o        (sts),
    .digit_char_o (digit_char)
  );

  // output word
  assign m_axis_tdata_o = {{(DATA_W - CHAR_W){1'b0}}, digit_char};
  assign m_axis_tlast_o = sts.one_left;

  // never taking a value while a digit is offered
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a digit is offered");

  // offered digits are always decimal characters
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit out of decimal range");

  // conversion follows an accepted value, not an immediate digit
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("digit offered right after accepting a value");

  // taking the last digit returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("not idle after last digit");

endmodule

// File: sv/b2da_dp.sv
// datapath: double-dabble digit register, bit and digit counters
module b2da_dp
  import b2da_pkg::*;
#(
  parameter int unsigned ND = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [VALUE_W-1:0] value_i,
  output sts_t               sts_o,
  output logic [CHAR_W-1:0]  digit_char_o
);

  localparam int unsigned BCD_W = 4 * ND;
  localparam int unsigned LW    = $clog2(ND + 1);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d, adj;
  logic [BITS_W-1:0]  bitcnt_q, bitcnt_d;
  logic [LW-1:0]      left_q, left_d;
  logic               ovf_q, ovf_d;

  // add 3 to every digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // next state of the digit register and counters
  always_comb begin
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    bitcnt_d = bitcnt_q;
    left_d   = left_q;
    ovf_d    = ovf_q;
    if (cmd_i.load) begin
      bin_d    = value_i;
      bcd_d    = '0;
      bitcnt_d = '0;
      left_d   = LW'(ND);
      ovf_d    = 1'b0;
    end else if (cmd_i.shift) begin
      bin_d    = bin_q << 1;
      bcd_d    = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bitcnt_d = bitcnt_q + 1'b1;
      // a carry out of the top digit means high digits were lost
      ovf_d    = ovf_q | adj[BCD_W-1];
    end else if (cmd_i.drop) begin
      bcd_d  = bcd_q << 4;
      left_d = left_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bitcnt_q <= '0;
      left_q   <= '0;
      ovf_q    <= 1'b0;
    end else begin
      bitcnt_q <= bitcnt_d;
      left_q   <= left_d;
      ovf_q    <= ovf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  // status and leading digit
  assign sts_o.bit_last = (bitcnt_q == LAST_BIT);
  assign sts_o.top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);
  assign sts_o.one_left = (left_q == LW'(1));
  assign sts_o.ovf      = ovf_q;
  assign digit_char_o   = ASCII_ZERO + {2'b00, bcd_q[BCD_W-1 -: 4]};

endmodule

// File: sv/b2da_ctrl.sv
// controller: accept, convert, skip leading zeros, emit digits
module b2da_ctrl
  import b2da_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // sequencing
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.bit_last) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // leading zeros go only when no high digit was lost
        if (!sts_i.ovf && sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.drop = 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (sts_i.one_left) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.drop = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sim/tb_top.sv
// testbench for the binary to decimal ascii converter: stream stimulus, predictor, digit checks
`timescale 1ns / 1ps

module tb_top;
  import b2da_pkg::*;

  localparam int unsigned DIGITS       = 10;
  localparam int unsigned DIGIT_CAP    = (DIGITS < 1) ? 1 : ((DIGITS > 20) ? 20 : DIGITS);
  localparam int unsigned RANDOM_ITEMS = 205;
  localparam int unsigned DRAIN_CYCLES = DIGITS + 45;
  localparam int unsigned STUCK_LIMIT  = 4000;

  // expected digit text per value and the checks against it
  class digit_scoreboard;
    typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [CHAR_W-1:0]  ch;
      logic               last;
    } digit_t;

    digit_t      expected_q[$];
    int unsigned errors;
    int unsigned values_seen;
    int unsigned digits_checked;

    function new();
      errors         = 0;
      values_seen    = 0;
      digits_checked = 0;
    endfunction

    // split the value into decimal digits, queue them most significant first
    function void note_value(input logic [VALUE_W-1:0] value);
      logic [3:0]         lsd_first [20];
      logic [VALUE_W-1:0] rest;
      int unsigned        count;
      int                 k;
      digit_t             d;
      rest  = value;
      count = 0;
      do begin
        lsd_first[count] = 4'(rest % 10);
        rest             = rest / 10;
        count++;
      end while (rest != 0 && count < DIGIT_CAP);
      for (k = int'(count) - 1; k >= 0; k--) begin
        d.value = value;
        d.ch    = ASCII_ZERO + {2'b00, lsd_first[k]};
        d.last  = (k == 0);
        expected_q.push_back(d);
      end
      values_seen++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // compare one output word with the oldest expected digit
    task check_digit(input logic [CHAR_W-1:0] ch, input logic last, input logic [1:0] pad);
      digit_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("digit 0x%02h last %0b with no value pending", ch, last));
        return;
      end
      want = expected_q.pop_front();
      digits_checked++;
      if (ch !== want.ch)
        report($sformatf("value %0d: digit_char 0x%02h, want 0x%02h", want.value, ch, want.ch));
      if (last !== want.last)
        report($sformatf("value %0d: last %0b, want %0b", want.value, last, want.last));
      if (pad !== 2'b00)
        report($sformatf("value %0d: pad bits %b not zero", want.value, pad));
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready_o;
  logic [VALUE_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata_o;
  logic               m_axis_tlast_o;

  int unsigned     send_idle_pct  = 9;
  int unsigned     recv_stall_pct = 70;
  int unsigned     stuck_cycles   = 0;
  int unsigned     directed_count = 0;
  digit_scoreboard sb = new();

  binary_to_decimal_ascii #(
    .MAX_DIGITS(DIGITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // note accepted values, check accepted digits
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o) sb.note_value(s_axis_tdata);
      if (m_axis_tvalid_o && m_axis_tready)
        sb.check_digit(m_axis_tdata_o[CHAR_W-1:0], m_axis_tlast_o,
                       m_axis_tdata_o[DATA_W-1:CHAR_W]);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[%0t] timeout: no handshake for %0d cycles", $realtime, STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // offer one value, with a random gap first; valid stays high after acceptance
  task automatic send_value(input logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // values spread over digit counts, small values, powers of ten, the top of the range and the full range
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned       kind;
    int unsigned       n;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   p;
    kind = $urandom_range(9);
    p    = 1;
    case (kind)
      4, 5, 6: begin
        n = $urandom_range(1, 10);
        repeat (n - 1) p = p * 10;
        lo = (n == 1) ? 0 : p;
        hi = p * 10 - 1;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
      end
      7: begin
        return VALUE_W'($urandom_range(99));
      end
      8: begin
        repeat ($urandom_range(9)) p = p * 10;
        return VALUE_W'(p + $urandom_range(2) - 1);
      end
      9: begin
        return 32'hFFFF_FFFF - VALUE_W'($urandom_range(1000));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  logic [VALUE_W-1:0] directed_values [] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101, 32'd1000, 32'd9999,
    32'd10000, 32'd100000, 32'd1000000, 32'd10000000, 32'd100000000, 32'd999999999,
    32'd1000000000, 32'd1000000001, 32'd2147483647, 32'd2147483648, 32'd4000000000,
    32'd4294967295, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890
  };

  initial begin
    int unsigned phase;
    int unsigned i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge values first, under the first pressure setting
    foreach (directed_values[j]) begin
      send_value(directed_values[j]);
      directed_count++;
    end

    // three pressure phases of random values
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 9;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (i = 0; i < RANDOM_ITEMS / 3 + ((phase == 0) ? RANDOM_ITEMS % 3 : 0); i++)
        send_value(random_value());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow for any late stray word
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d values (%0d edge cases) giving %0d digits,",
             sb.values_seen, directed_count, sb.digits_checked);
    $display("with stalls on either side and a phase without stalls; %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
